FILE: rtl/utf8_stream_decoder_macros.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define UTF8D_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("utf8d assertion failed");
// Next-cycle implication, disabled during reset.
`define UTF8D_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("utf8d assertion failed");
`else
`define UTF8D_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UTF8D_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/utf8d_pkg.sv
// Types, constants and helper functions of the UTF-8 stream decoder.
// No dependencies; used by the decoder modules and the testbench.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned CntW  = 3;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrBadLead   = 2'd1,
    ErrBadCont   = 2'd2,
    ErrTruncated = 2'd3
  } err_e;

  // Tail byte count for lead bytes 0xF0-0xFF, indexed by the low nibble.
  localparam logic [CntW-1:0] HighTails [16] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd0, 3'd0
  };

  // Registered byte handed from the input stage to the decode stage.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] in_byte;
    logic             in_end;
  } byte_item_t;

  // Number of continuation bytes a lead byte announces; zero if it is no lead.
  function automatic logic [CntW-1:0] tail_count(input logic [ByteW-1:0] b);
    logic [CntW-1:0] n;
    if (b < 8'hC0) begin
      n = 3'd0;
    end else if (b < 8'hE0) begin
      n = 3'd1;
    end else if (b < 8'hF0) begin
      n = 3'd2;
    end else begin
      n = HighTails[b[3:0]];
    end
    return n;
  endfunction

endpackage

FILE: rtl/utf8d_if.sv
// Valid/ready stream interfaces of the UTF-8 stream decoder.
// Byte input channel and code point result channel; no dependencies.
`timescale 1ns / 1ps

interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic [1:0]  error_kind;
  logic        stream_done;

  modport source (output valid, output code_point, output error_kind,
                  output stream_done, input ready);
  modport sink (input valid, input code_point, input error_kind,
                input stream_done, output ready);
endinterface

FILE: rtl/utf8d_in_reg.sv
// Input register stage of the UTF-8 stream decoder.
// Depends on utf8d_pkg and the utf8d_byte_if interface.
`timescale 1ns / 1ps

module utf8d_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  utf8d_byte_if.sink            byte_i,
  output utf8d_pkg::byte_item_t item_o,
  input  logic                  item_ready_i
);
  import utf8d_pkg::*;

  logic             vld_q;
  logic [ByteW-1:0] byte_q;
  logic             end_q;

  // The register takes a new transfer whenever it is empty or drains this cycle.
  assign byte_i.ready = !vld_q || item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.in_byte;
      end_q  <= byte_i.in_end;
    end
  end

  assign item_o = '{valid: vld_q, in_byte: byte_q, in_end: end_q};

endmodule

FILE: rtl/utf8d_decode.sv
// Decode stage of the UTF-8 stream decoder: sequence state and result register.
// Depends on utf8d_pkg, utf8d_cp_if and utf8_stream_decoder_macros.svh.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"

module utf8d_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  utf8d_pkg::byte_item_t item_i,
  output logic                  item_ready_o,
  utf8d_cp_if.source            cp_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0]   pv_q, pv_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             res_vld_q, res_vld_d;
  logic [CpW-1:0]   res_cp_q;
  err_e             res_err_q;
  logic             res_done_q;

  logic             consume;
  logic             emit;
  logic [CpW-1:0]   emit_cp;
  err_e             emit_err;
  logic             emit_done;
  logic [CntW-1:0]  tail;
  logic [ByteW-1:0] lead_mask;
  logic [CpW-1:0]   shifted;
  logic [CntW-1:0]  cnt_dec;

  assign item_ready_o = !res_vld_q || cp_o.ready;
  assign consume      = item_i.valid && item_ready_o;

  assign tail      = tail_count(item_i.in_byte);
  assign lead_mask = 8'h3F >> tail;
  assign shifted   = {pv_q[CpW-7:0], item_i.in_byte[5:0]};
  assign cnt_dec   = cnt_q - 3'd1;

  always_comb begin
    pv_d      = pv_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    emit_cp   = '0;
    emit_err  = ErrNone;
    emit_done = item_i.in_end;
    if (cnt_q == 3'd0) begin
      if (!item_i.in_byte[7]) begin
        emit    = 1'b1;
        emit_cp = {{(CpW-ByteW){1'b0}}, item_i.in_byte};
      end else if (tail == 3'd0) begin
        emit     = 1'b1;
        emit_err = ErrBadLead;
      end else if (item_i.in_end) begin
        emit     = 1'b1;
        emit_err = ErrTruncated;
      end else begin
        pv_d  = {{(CpW-ByteW){1'b0}}, item_i.in_byte & lead_mask};
        cnt_d = tail;
      end
    end else if (item_i.in_byte[7:6] != 2'b10) begin
      // A non-continuation byte aborts the sequence and is itself dropped.
      emit     = 1'b1;
      emit_err = ErrBadCont;
      pv_d     = '0;
      cnt_d    = 3'd0;
    end else if (cnt_dec == 3'd0) begin
      emit    = 1'b1;
      emit_cp = shifted;
      pv_d    = '0;
      cnt_d   = 3'd0;
    end else if (item_i.in_end) begin
      emit     = 1'b1;
      emit_err = ErrTruncated;
      pv_d     = '0;
      cnt_d    = 3'd0;
    end else begin
      pv_d  = shifted;
      cnt_d = cnt_dec;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q && !cp_o.ready;
    if (consume && emit) begin
      res_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= '0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
      if (consume) begin
        pv_q  <= pv_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && emit) begin
      res_cp_q   <= emit_cp;
      res_err_q  <= emit_err;
      res_done_q <= emit_done;
    end
  end

  assign cp_o.valid       = res_vld_q;
  assign cp_o.code_point  = res_cp_q;
  assign cp_o.error_kind  = res_err_q;
  assign cp_o.stream_done = res_done_q;

  `UTF8D_ASSERT_IMP(a_err_zero_cp, clk_i, rst_ni, res_vld_q && (res_err_q != ErrNone), res_cp_q == '0)
  `UTF8D_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= 3'd5)
  `UTF8D_ASSERT_NXT(a_end_idle, clk_i, rst_ni, consume && item_i.in_end, cnt_q == 3'd0)
  `UTF8D_ASSERT_IMP(a_trunc_done, clk_i, rst_ni, res_vld_q && (res_err_q == ErrTruncated), res_done_q)

endmodule

FILE: rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder (original six-byte form).
// Depends on utf8d_pkg, utf8d_if, utf8d_in_reg and utf8d_decode.
//
// The decoder takes bytes on byte_i and returns code points on
// cp_o. It sustains one byte per cycle while results are taken. A byte is
// held in the input register and its result in the result register, and the
// sequence state is updated in the single decode stage between them. ASCII
// bytes and final continuation bytes give a result; lead bytes and inner
// continuation bytes give none unless they end the stream or are in error.
// Errors (bad lead, bad continuation, truncated at end of stream) give a
// result with a zero code point and resynchronize.
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  utf8d_byte_if.sink   byte_i,
  utf8d_cp_if.source   cp_o
);
  import utf8d_pkg::*;

  byte_item_t item;
  logic       item_ready;

  utf8d_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  utf8d_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_ready_o (item_ready),
    .cp_o         (cp_o)
  );

endmodule

FILE: bench/tb_utf8_stream_decoder.sv
// Self-checking testbench of utf8_stream_decoder: directed sequences, then random byte streams.
// Depends on utf8d_pkg and the utf8d_byte_if / utf8d_cp_if interfaces of the RTL.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import utf8d_pkg::*;

  localparam int RandItems  = 1050;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 8;

  typedef struct packed {
    logic [CpW-1:0] cp;
    err_e           err;
    logic           done;
  } cp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  utf8d_byte_if byte_if ();
  utf8d_cp_if   cp_if ();

  utf8_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cp_o   (cp_if)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: payload gathered so far and continuation bytes still owed.
  logic [CpW-1:0]  seq_partial;
  logic [CntW-1:0] seq_tails_left;

  cp_result_t pending_results[$];
  int         fail_count = 0;
  int         cycle_count;
  bit         src_idle_on = 1'b1;
  bit         snk_idle_on = 1'b1;

  function automatic int gap_len(input bit on);
    int r;
    r = $urandom_range(99);
    if (!on || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CntW-1:0] lead_tails(input logic [7:0] b);
    logic [CntW-1:0] n;
    casez (b)
      8'b110?????: n = 3'd1;
      8'b1110????: n = 3'd2;
      8'b11110???: n = 3'd3;
      8'b111110??: n = 3'd4;
      8'b1111110?: n = 3'd5;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  // Advances the predictor by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                     output cp_result_t r);
    logic [CntW-1:0] tails;
    r = '{cp: '0, err: ErrNone, done: fin};
    if (seq_tails_left == 0) begin
      if (!b[7]) begin
        r.cp = CpW'(b);
        return 1'b1;
      end
      tails = lead_tails(b);
      if (tails == 0) begin
        r.err = ErrBadLead;
        return 1'b1;
      end
      if (fin) begin
        r.err = ErrTruncated;
        return 1'b1;
      end
      seq_partial    = CpW'(b & (8'h3F >> tails));
      seq_tails_left = tails;
      return 1'b0;
    end
    if (b[7:6] != 2'b10) begin
      seq_partial    = '0;
      seq_tails_left = '0;
      r.err = ErrBadCont;
      return 1'b1;
    end
    seq_partial    = {seq_partial[CpW-7:0], b[5:0]};
    seq_tails_left = seq_tails_left - 1'b1;
    if (seq_tails_left == 0) begin
      r.cp        = seq_partial;
      seq_partial = '0;
      return 1'b1;
    end
    if (fin) begin
      seq_partial    = '0;
      seq_tails_left = '0;
      r.err = ErrTruncated;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Lead byte of a well-formed sequence of len bytes, with random payload bits.
  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      4:       return {5'b11110, r[2:0]};
      5:       return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int         gap;
    cp_result_t r;
    gap = gap_len(src_idle_on);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    byte_if.in_end  <= fin;
    do @(posedge clk_i); while (!byte_if.ready);
    if (decode_byte(b, fin, r)) pending_results.insert(pending_results.size(), r);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$], input logic fin_last);
    foreach (seq[i]) send_byte(seq[i], fin_last && (i == seq.size() - 1));
  endtask

  // Well-formed sequences of one, two, three, four and six bytes; most carry the payload at an extreme.
  task automatic test_sequence_lengths();
    send_bytes('{8'h00}, 1'b0);
    send_bytes('{8'h7F}, 1'b1);
    send_bytes('{8'hDF, 8'hBF}, 1'b0);
    send_bytes('{8'hEF, 8'hBF, 8'hBF}, 1'b0);
    send_bytes('{8'hF7, 8'h80, 8'h80, 8'h80}, 1'b0);
    send_bytes('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF}, 1'b0);
  endtask

  task automatic test_error_cases();
    // Stray continuation and a lead byte that announces nothing.
    send_bytes('{8'h80}, 1'b0);
    send_bytes('{8'hFE}, 1'b0);
    // An ASCII byte breaks an open sequence and is dropped, not decoded.
    send_bytes('{8'hC3, 8'h41}, 1'b0);
    // A final byte that is a bad continuation reports only the bad continuation.
    send_bytes('{8'hE2, 8'hC3}, 1'b1);
    // Streams that end on a lead byte or on an inner continuation.
    send_bytes('{8'hFC}, 1'b1);
    send_bytes('{8'hE2, 8'h82}, 1'b1);
  endtask

  // Mostly well-formed sequences, with broken sequences and raw noise bytes between them.
  task automatic test_random_streams();
    int         sent;
    int         seqs;
    int         kind;
    int         len;
    int         ncont;
    int         r;
    bit         fin;
    bit         cut_by_end;
    logic [7:0] b;
    sent = 0;
    seqs = 0;
    while (sent < RandItems) begin
      if (seqs % 40 == 0) begin
        src_idle_on = $urandom_range(3) != 0;
        snk_idle_on = $urandom_range(3) != 0;
      end
      seqs++;
      kind = $urandom_range(99);
      r    = $urandom_range(99);
      len  = r < 30 ? 1 : r < 50 ? 2 : r < 68 ? 3 : r < 82 ? 4 : r < 92 ? 5 : 6;
      fin  = $urandom_range(19) == 0;
      if (kind < 75) begin
        for (int i = 0; i < len; i++) begin
          send_byte(i == 0 ? lead_byte(len) : cont_byte(), fin && (i == len - 1));
        end
        sent += len;
      end else if (kind < 88) begin
        if (len < 2) len = 2;
        cut_by_end = $urandom_range(1);
        ncont      = $urandom_range(len - 2);
        send_byte(lead_byte(len), cut_by_end && (ncont == 0));
        for (int i = 0; i < ncont; i++) begin
          send_byte(cont_byte(), cut_by_end && (i == ncont - 1));
        end
        sent += 1 + ncont;
        if (!cut_by_end) begin
          do b = 8'($urandom); while (b[7:6] == 2'b10);
          send_byte(b, $urandom_range(3) == 0);
          sent++;
        end
      end else begin
        send_byte(8'($urandom), $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  // Result side: random back-pressure and the comparison of every transfer.
  initial begin
    int         stall_left;
    logic       next_ready;
    cp_result_t want;
    stall_left  = 0;
    cp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && cp_if.valid && cp_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result cp=%h err=%0d done=%b", $time,
                   cp_if.code_point, cp_if.error_kind, cp_if.stream_done);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (cp_if.code_point !== want.cp) begin
            $display("%0t: code_point expected %h actual %h", $time, want.cp,
                     cp_if.code_point);
            fail_count++;
          end
          if (cp_if.error_kind !== want.err) begin
            $display("%0t: error_kind expected %0d actual %0d", $time, want.err,
                     cp_if.error_kind);
            fail_count++;
          end
          if (cp_if.stream_done !== want.done) begin
            $display("%0t: stream_done expected %b actual %b", $time, want.done,
                     cp_if.stream_done);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if ($urandom_range(9) < 3) stall_left = gap_len(snk_idle_on);
      end
      cp_if.ready <= next_ready;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_utf8_stream_decoder: FAIL");
    $finish;
  end

  initial begin
    seq_partial     = '0;
    seq_tails_left  = '0;
    rst_ni          <= 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.in_byte <= '0;
    byte_if.in_end  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sequence_lengths();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    test_error_cases();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    test_random_streams();
    byte_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_utf8_stream_decoder: PASS");
    end else begin
      $display("tb_utf8_stream_decoder: FAIL");
    end
    $finish;
  end

endmodule
